[design/histogram_with_occupancy_scan_macros.svh]
// Assertion macros for the histogram block checker.
`ifndef HISTOGRAM_WITH_OCCUPANCY_SCAN_MACROS_SVH
`define HISTOGRAM_WITH_OCCUPANCY_SCAN_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HWOS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define HWOS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/hwos_pkg.sv]
// Shared constants, codes and controller/datapath types for the histogram block.
`default_nettype none
package hwos_pkg;
	localparam int BIN_COUNT_DEF  = 16384;
	localparam int COUNT_BITS_DEF = 32;
	localparam int OP_W           = 2;
	localparam int IDX_W          = 16;
	localparam int BIN_W          = 14;
	localparam int NZ_W           = 15;
	localparam int TOTAL_W        = 32;
	localparam logic [BIN_W-1:0] SCAN_START_RST = BIN_W'(150);

	typedef enum logic [OP_W-1:0] {
		OP_ADD     = 2'd0,
		OP_CLEAR   = 2'd1,
		OP_ANALYZE = 2'd2
	} op_t;

	typedef struct packed {
		logic addr_load_index;
		logic addr_load_zero;
		logic addr_load_start;
		logic addr_inc;
		logic mem_rd;
		logic scan_rd;
		logic mem_wr_zero;
		logic mem_wr_inc;
		logic total_clr;
		logic total_inc;
		logic acc_clr;
		logic out_load;
	} hwos_cmd_t;

	typedef struct packed {
		logic index_oob;
		logic start_oob;
		logic addr_last;
		logic out_free;
	} hwos_sts_t;
endpackage
`default_nettype wire

[design/hwos_ifs.sv]
// Valid/ready channel interfaces for command items and analysis results.
`default_nettype none
interface hwos_in_if
	import hwos_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  opcode;
	logic [IDX_W-1:0] bin_index;

	modport source (output valid, output opcode, output bin_index, input ready);
	modport sink (input valid, input opcode, input bin_index, output ready);
endinterface

interface hwos_out_if
	import hwos_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               any_found;
	logic [BIN_W-1:0]   first_bin;
	logic [BIN_W-1:0]   last_bin;
	logic [NZ_W-1:0]    nonzero_bins;
	logic [TOTAL_W-1:0] entry_total;

	modport source (output valid, output any_found, output first_bin, output last_bin,
		output nonzero_bins, output entry_total, input ready);
	modport sink (input valid, input any_found, input first_bin, input last_bin,
		input nonzero_bins, input entry_total, output ready);
endinterface
`default_nettype wire

[design/histogram_with_occupancy_scan.sv]
// Histogram of saturating bin counters with clear and occupancy scan; top level.
// Add: read, then saturating write on one port; an out-of-range index is dropped.
// Clear: zeroes every bin, one bin written per cycle through the single memory port.
// Analyze: scans scan_start_bin to the last bin, then loads the result once the output is free.
// Reset: a clearing pass zeroes the bins, input ready stays low meanwhile.
// Reset restores scan_start_bin to 150 and zeroes the entry total.
`default_nettype none
module histogram_with_occupancy_scan
	import hwos_pkg::*;
#(
	parameter int BIN_COUNT  = BIN_COUNT_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [BIN_W-1:0] cfg_wr_data,
	hwos_in_if.sink               in_ch,
	hwos_out_if.source            out_ch
);
	hwos_cmd_t cmd;
	hwos_sts_t sts;

	hwos_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_opcode (in_ch.opcode),
		.in_ready  (in_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hwos_dp #(
		.BIN_COUNT  (BIN_COUNT),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_bin_index (in_ch.bin_index),
		.out_ready    (out_ch.ready),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_ch.valid),
		.any_found    (out_ch.any_found),
		.first_bin    (out_ch.first_bin),
		.last_bin     (out_ch.last_bin),
		.nonzero_bins (out_ch.nonzero_bins),
		.entry_total  (out_ch.entry_total)
	);
endmodule
`default_nettype wire

[design/hwos_ctrl.sv]
// Controller state machine: sequences adds, clear sweeps and occupancy scans.
`default_nettype none
module hwos_ctrl
	import hwos_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic [OP_W-1:0] in_opcode,
	output logic                 in_ready,
	input  wire hwos_sts_t       sts,
	output hwos_cmd_t            cmd
);
	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_ADD_RD,
		S_ADD_WR,
		S_CLR,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_INIT, S_CLR: begin
				cmd.mem_wr_zero = 1'b1;
				cmd.addr_inc    = 1'b1;
				if (sts.addr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					unique case (in_opcode)
						OP_ADD: begin
							if (!sts.index_oob) begin
								cmd.addr_load_index = 1'b1;
								state_d = S_ADD_RD;
							end
						end
						OP_CLEAR: begin
							cmd.addr_load_zero = 1'b1;
							cmd.total_clr      = 1'b1;
							state_d = S_CLR;
						end
						OP_ANALYZE: begin
							cmd.addr_load_start = 1'b1;
							cmd.acc_clr         = 1'b1;
							state_d = sts.start_oob ? S_DONE : S_SCAN;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_ADD_RD: begin
				cmd.mem_rd = 1'b1;
				state_d = S_ADD_WR;
			end
			S_ADD_WR: begin
				cmd.mem_wr_inc = 1'b1;
				cmd.total_inc  = 1'b1;
				state_d = S_IDLE;
			end
			S_SCAN: begin
				cmd.scan_rd  = 1'b1;
				cmd.addr_inc = 1'b1;
				if (sts.addr_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

[design/hwos_dp.sv]
// Datapath: bin memory, address counter, total, scan accumulators and result register.
`default_nettype none
module hwos_dp
	import hwos_pkg::*;
#(
	parameter int BIN_COUNT  = BIN_COUNT_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [BIN_W-1:0] cfg_wr_data,
	input  wire logic [IDX_W-1:0] in_bin_index,
	input  wire logic             out_ready,
	input  wire hwos_cmd_t        cmd,
	output hwos_sts_t             sts,
	output logic                  out_valid,
	output logic                  any_found,
	output logic [BIN_W-1:0]      first_bin,
	output logic [BIN_W-1:0]      last_bin,
	output logic [NZ_W-1:0]       nonzero_bins,
	output logic [TOTAL_W-1:0]    entry_total
);
	localparam int ADDR_W = $clog2(BIN_COUNT);
	localparam logic [IDX_W:0]    BIN_LIMIT = (IDX_W+1)'(BIN_COUNT);
	localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(BIN_COUNT - 1);

	logic [COUNT_BITS-1:0] mem [BIN_COUNT];

	logic [BIN_W-1:0]        start_q;
	logic [ADDR_W-1:0]       addr_q;
	logic [COUNT_BITS-1:0]   total_q;
	logic [COUNT_BITS-1:0]   rd_data_s1;
	logic [ADDR_W-1:0]       rd_addr_s1;
	logic                    rd_valid_s1;
	logic                    found_q;
	logic [BIN_W-1:0]        first_q;
	logic [BIN_W-1:0]        last_q;
	logic [NZ_W-1:0]         nz_q;
	logic                    out_valid_q;
	logic                    out_found_q;
	logic [BIN_W-1:0]        out_first_q;
	logic [BIN_W-1:0]        out_last_q;
	logic [NZ_W-1:0]         out_nz_q;
	logic [TOTAL_W-1:0]      out_total_q;

	logic [ADDR_W+BIN_W-1:0]     start_ext;
	logic [ADDR_W+BIN_W-1:0]     rd_addr_ext;
	logic [COUNT_BITS+TOTAL_W-1:0] total_ext;
	logic [COUNT_BITS-1:0]       wr_data;
	logic                        hit;

	assign start_ext   = {{ADDR_W{1'b0}}, start_q};
	assign rd_addr_ext = {{BIN_W{1'b0}}, rd_addr_s1};
	assign total_ext   = {{TOTAL_W{1'b0}}, total_q};

	assign sts.index_oob = ({1'b0, in_bin_index} >= BIN_LIMIT);
	assign sts.start_oob = ((IDX_W+1)'(start_q) >= BIN_LIMIT);
	assign sts.addr_last = (addr_q == ADDR_LAST);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign wr_data = cmd.mem_wr_inc ?
		((rd_data_s1 == '1) ? rd_data_s1 : rd_data_s1 + 1'b1) : '0;
	assign hit = rd_valid_s1 && (rd_data_s1 != '0);

	always_ff @(posedge clk) begin
		if (cmd.mem_wr_zero || cmd.mem_wr_inc) begin
			mem[addr_q] <= wr_data;
		end
		if (cmd.mem_rd || cmd.scan_rd) begin
			rd_data_s1 <= mem[addr_q];
		end
		rd_addr_s1 <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= SCAN_START_RST;
			addr_q      <= '0;
			total_q     <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				start_q <= cfg_wr_data;
			end
			if (cmd.addr_load_index) begin
				addr_q <= in_bin_index[ADDR_W-1:0];
			end else if (cmd.addr_load_zero) begin
				addr_q <= '0;
			end else if (cmd.addr_load_start) begin
				addr_q <= start_ext[ADDR_W-1:0];
			end else if (cmd.addr_inc) begin
				addr_q <= addr_q + 1'b1;
			end
			if (cmd.total_clr) begin
				total_q <= '0;
			end else if (cmd.total_inc && (total_q != '1)) begin
				total_q <= total_q + 1'b1;
			end
			rd_valid_s1 <= cmd.scan_rd;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			found_q <= 1'b0;
			first_q <= '0;
			last_q  <= '0;
			nz_q    <= '0;
		end else if (hit) begin
			if (!found_q) begin
				first_q <= rd_addr_ext[BIN_W-1:0];
			end
			found_q <= 1'b1;
			last_q  <= rd_addr_ext[BIN_W-1:0];
			if (nz_q != '1) begin
				nz_q <= nz_q + 1'b1;
			end
		end
		if (cmd.out_load) begin
			out_found_q <= found_q;
			out_first_q <= first_q;
			out_last_q  <= last_q;
			out_nz_q    <= nz_q;
			out_total_q <= total_ext[TOTAL_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign any_found    = out_found_q;
	assign first_bin    = out_first_q;
	assign last_bin     = out_last_q;
	assign nonzero_bins = out_nz_q;
	assign entry_total  = out_total_q;
endmodule
`default_nettype wire

[design/hwos_chk.sv]
// Port-level checker for the histogram block and its bind.
`default_nettype none
`include "histogram_with_occupancy_scan_macros.svh"
module hwos_chk
	import hwos_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic [OP_W-1:0]  in_opcode,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic             any_found,
	input wire logic [BIN_W-1:0] first_bin,
	input wire logic [BIN_W-1:0] last_bin,
	input wire logic [NZ_W-1:0]  nonzero_bins
);
	`HWOS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped before transfer")
	`HWOS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready && (in_opcode == OP_CLEAR || in_opcode == OP_ANALYZE), !in_ready, "input taken while busy")
	`HWOS_ASSERT_NOW(a_none_zero, out_valid && !any_found, first_bin == '0 && last_bin == '0 && nonzero_bins == '0, "empty scan with nonzero fields")
	`HWOS_ASSERT_NOW(a_found_count, out_valid && any_found, nonzero_bins != '0, "found with zero count")
endmodule

bind histogram_with_occupancy_scan hwos_chk u_hwos_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.in_opcode    (in_ch.opcode),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.any_found    (out_ch.any_found),
	.first_bin    (out_ch.first_bin),
	.last_bin     (out_ch.last_bin),
	.nonzero_bins (out_ch.nonzero_bins)
);
`default_nettype wire
